### rtl/uplink_priority_selector_table_macros.svh
// Assertion macros shared by the uplink priority selector table RTL.
// Every macro samples on clk_i and expects rst_ni in the scope where it is used.
`ifndef UPLINK_PRIORITY_SELECTOR_TABLE_MACROS_SVH
`define UPLINK_PRIORITY_SELECTOR_TABLE_MACROS_SVH

// Checked only while the block is out of reset.
`define UPST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, during reset too.
`define UPST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/upst_pkg.sv
// Shared types and constants for the uplink priority selector table.
// Used by upst_ctrl, upst_datapath and the top level; depends on nothing.
package upst_pkg;

  localparam int unsigned SlotsDefault = 8;

  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_UNREGISTER = 2'd1,
    REQ_SET_READY  = 2'd2,
    REQ_QUERY      = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0]        iface;
    logic [31:0]        name;
    logic signed [15:0] prio;
  } slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // capture the request fields
    logic scan_start;  // restart the slot scan and clear its results
    logic scan_run;    // step the slot scan
    logic pick;        // scan selects the active uplink rather than searching
    logic apply;       // settle the status and update the table
    logic finish;      // load the result registers
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic is_query;
  } sts_t;

endpackage

### rtl/upst_ctrl.sv
// Controller state machine for the uplink priority selector table.
// Depends on upst_pkg and uplink_priority_selector_table_macros.svh.
`include "uplink_priority_selector_table_macros.svh"

module upst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  upst_pkg::sts_t  sts_i,
  output upst_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FIND   = 5'b00010,
    S_APPLY  = 5'b00100,
    S_PICK   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch      = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = S_FIND;
        end
      end
      S_FIND: begin
        // A query leaves the table alone, so the search scan is skipped.
        if (sts_i.is_query) begin
          state_d = S_APPLY;
        end else begin
          cmd_o.scan_run = 1'b1;
          if (sts_i.scan_done) begin
            state_d = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        cmd_o.apply      = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_PICK;
      end
      S_PICK: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.pick     = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `UPST_ASSERT(a_accept_starts_search, in_valid_i && in_ready_o |=> state_q == S_FIND,
               "accepted transaction did not start the search")
  `UPST_ASSERT(a_pick_done_finishes, state_q == S_PICK && sts_i.scan_done |=> state_q == S_FINISH,
               "selection scan did not end in the finish state")
  `UPST_ASSERT(a_result_from_finish, $rose(out_valid_o) |-> $past(state_q == S_FINISH),
               "result raised outside the finish state")

endmodule

### rtl/upst_datapath.sv
// Datapath of the uplink priority selector table: slot memory, scan unit,
// status logic and result registers. Depends on upst_pkg and the macro header.
`include "uplink_priority_selector_table_macros.svh"

module upst_datapath #(
  parameter int unsigned Slots = upst_pkg::SlotsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  upst_pkg::cmd_t     cmd_i,
  output upst_pkg::sts_t     sts_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        iface_id_i,
  input  logic [31:0]        name_key_i,
  input  logic signed [15:0] route_prio_i,
  input  logic               ready_value_i,
  input  logic [15:0]        default_iface_i,
  output logic [2:0]         status_o,
  output logic               changed_o,
  output logic               active_valid_o,
  output logic [15:0]        active_iface_o,
  output logic [31:0]        active_name_o,
  output logic signed [15:0] active_prio_o
);

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW = $clog2(Slots + 1);

  // Latched request.
  upst_pkg::req_e     req_q;
  logic [15:0]        iface_q;
  logic [31:0]        name_q;
  logic signed [15:0] prio_q;
  logic               rdy_q;
  logic [15:0]        def_q;

  // Slot table: flags in flip-flops, payload in memory.
  logic [Slots-1:0]   used_q, used_d;
  logic [Slots-1:0]   ready_q, ready_d;
  upst_pkg::slot_t    mem [Slots];

  // Scan unit.
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]    rd_idx_q;
  upst_pkg::slot_t    rd_data_q;
  logic               mem_re;
  logic               scan_done;
  logic               eval;
  logic               cur_used;
  logic               cur_ready;
  logic               iface_hit;
  logic               name_hit;
  logic               better;

  // Search results.
  logic               dup_q, dup_d;
  logic               found_q, found_d;
  logic [IdxW-1:0]    found_idx_q, found_idx_d;
  logic               free_q, free_d;
  logic [IdxW-1:0]    free_idx_q, free_idx_d;

  // Best candidate of the selection scan.
  logic               best_vld_q, best_vld_d;
  logic [15:0]        best_iface_q, best_iface_d;
  logic [31:0]        best_name_q, best_name_d;
  logic signed [15:0] best_prio_q, best_prio_d;

  // Outcome of the request.
  upst_pkg::status_e  st_q, st_d;
  logic               chg_q;
  logic               req_ok;
  logic               mem_we;

  // Result registers.
  logic [2:0]         status_q;
  logic               changed_q;
  logic               active_valid_q;
  logic [15:0]        active_iface_q;
  logic [31:0]        active_name_q;
  logic signed [15:0] active_prio_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q   <= upst_pkg::req_e'(req_type_i);
      iface_q <= iface_id_i;
      name_q  <= name_key_i;
      prio_q  <= route_prio_i;
      rdy_q   <= ready_value_i;
      def_q   <= default_iface_i;
    end
  end

  assign scan_done = (cnt_q == CntW'(Slots));
  assign mem_re    = cmd_i.scan_run && !scan_done;
  assign eval      = cmd_i.scan_run && rd_vld_q;
  assign cur_used  = used_q[rd_idx_q];
  assign cur_ready = ready_q[rd_idx_q];
  assign iface_hit = (rd_data_q.iface == iface_q);
  assign name_hit  = (rd_data_q.name == name_q);

  // Later tied slots only win when they carry the default interface.
  assign better = !best_vld_q
               || ($signed(rd_data_q.prio) > $signed(best_prio_q))
               || (($signed(rd_data_q.prio) == $signed(best_prio_q))
                   && (rd_data_q.iface == def_q));

  always_comb begin
    cnt_d    = cnt_q;
    rd_vld_d = rd_vld_q;
    if (cmd_i.scan_start) begin
      cnt_d    = '0;
      rd_vld_d = 1'b0;
    end else if (cmd_i.scan_run) begin
      rd_vld_d = mem_re;
      if (mem_re) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_comb begin
    dup_d        = dup_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    best_vld_d   = best_vld_q;
    best_iface_d = best_iface_q;
    best_name_d  = best_name_q;
    best_prio_d  = best_prio_q;
    if (cmd_i.scan_start) begin
      dup_d      = 1'b0;
      found_d    = 1'b0;
      free_d     = 1'b0;
      best_vld_d = 1'b0;
    end else if (eval && cmd_i.pick) begin
      if (cur_used && cur_ready && better) begin
        best_vld_d   = 1'b1;
        best_iface_d = rd_data_q.iface;
        best_name_d  = rd_data_q.name;
        best_prio_d  = rd_data_q.prio;
      end
    end else if (eval) begin
      if (cur_used && (iface_hit || name_hit)) begin
        dup_d = 1'b1;
      end
      if (cur_used && iface_hit && !found_q) begin
        found_d     = 1'b1;
        found_idx_d = rd_idx_q;
      end
      if (!cur_used && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = rd_idx_q;
      end
    end
  end

  always_comb begin
    st_d = upst_pkg::ST_OK;
    unique case (req_q)
      upst_pkg::REQ_REGISTER: begin
        if (iface_q == 16'd0 || name_q == 32'd0) begin
          st_d = upst_pkg::ST_INVALID;
        end else if (dup_q) begin
          st_d = upst_pkg::ST_DUPLICATE;
        end else if (!free_q) begin
          st_d = upst_pkg::ST_FULL;
        end
      end
      upst_pkg::REQ_UNREGISTER, upst_pkg::REQ_SET_READY: begin
        if (iface_q == 16'd0) begin
          st_d = upst_pkg::ST_INVALID;
        end else if (!found_q) begin
          st_d = upst_pkg::ST_NOT_FOUND;
        end
      end
      upst_pkg::REQ_QUERY: begin
        st_d = upst_pkg::ST_OK;
      end
      default: begin
        st_d = upst_pkg::ST_OK;
      end
    endcase
  end

  assign req_ok = cmd_i.apply && (st_d == upst_pkg::ST_OK) && (req_q != upst_pkg::REQ_QUERY);
  assign mem_we = req_ok && (req_q == upst_pkg::REQ_REGISTER);

  always_comb begin
    used_d  = used_q;
    ready_d = ready_q;
    if (req_ok) begin
      unique case (req_q)
        upst_pkg::REQ_REGISTER: begin
          used_d[free_idx_q]  = 1'b1;
          ready_d[free_idx_q] = 1'b0;
        end
        upst_pkg::REQ_UNREGISTER: begin
          used_d[found_idx_q]  = 1'b0;
          ready_d[found_idx_q] = 1'b0;
        end
        upst_pkg::REQ_SET_READY: begin
          ready_d[found_idx_q] = rdy_q;
        end
        default: begin
          used_d  = used_q;
          ready_d = ready_q;
        end
      endcase
    end
  end

  // Slot payload memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[free_idx_q] <= '{iface: iface_q, name: name_q, prio: prio_q};
    end
    if (mem_re) begin
      rd_data_q <= mem[cnt_q[IdxW-1:0]];
      rd_idx_q  <= cnt_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      ready_q    <= '0;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      dup_q      <= 1'b0;
      found_q    <= 1'b0;
      free_q     <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      used_q     <= used_d;
      ready_q    <= ready_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      dup_q      <= dup_d;
      found_q    <= found_d;
      free_q     <= free_d;
      best_vld_q <= best_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_idx_q  <= found_idx_d;
    free_idx_q   <= free_idx_d;
    best_iface_q <= best_iface_d;
    best_name_q  <= best_name_d;
    best_prio_q  <= best_prio_d;
    if (cmd_i.apply) begin
      st_q  <= st_d;
      chg_q <= req_ok;
    end
    if (cmd_i.finish) begin
      status_q       <= st_q;
      changed_q      <= chg_q;
      active_valid_q <= best_vld_q;
      active_iface_q <= best_vld_q ? best_iface_q : 16'd0;
      active_name_q  <= best_vld_q ? best_name_q : 32'd0;
      active_prio_q  <= best_vld_q ? best_prio_q : 16'sd0;
    end
  end

  assign sts_o.scan_done = scan_done;
  assign sts_o.is_query  = (req_q == upst_pkg::REQ_QUERY);

  assign status_o       = status_q;
  assign changed_o      = changed_q;
  assign active_valid_o = active_valid_q;
  assign active_iface_o = active_iface_q;
  assign active_name_o  = active_name_q;
  assign active_prio_o  = active_prio_q;

  `UPST_ASSERT(a_write_to_free_slot, mem_we |-> !used_q[free_idx_q],
               "register wrote over a slot in use")
  `UPST_ASSERT(a_finish_after_pick, $past(cmd_i.finish) && cmd_i.apply |-> 1'b0,
               "new request applied directly after a finish")
  `UPST_ASSERT(a_change_means_ok, cmd_i.apply && req_ok |-> st_d == upst_pkg::ST_OK,
               "table changed on a failed request")

endmodule

### rtl/uplink_priority_selector_table.sv
// Top level of the uplink priority selector table.
// Instantiates upst_ctrl and upst_datapath; types come from upst_pkg.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-------------------------------------------
//   request | in_valid_i / in_ready_o | req_type, iface_id, name_key, route_prio,
//           |                        | ready_value, default_iface
//   result  | out_valid_o / out_ready_i | status, changed, active_valid,
//           |                        | active_iface, active_name, active_prio
//
// Results are registered in the finish step, after a search scan of the slots
// (skipped for a query), the apply step and a selection scan, and a new
// request is accepted only once the block is back in idle.
// Both slot scans go through the single read port of the slot memory.
// Reset clears all slot flags at once; the slot memory needs no clearing.
// A waiting result stalls the next request only in its finish step.

module uplink_priority_selector_table #(
  parameter int unsigned Slots = upst_pkg::SlotsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        iface_id_i,
  input  logic [31:0]        name_key_i,
  input  logic signed [15:0] route_prio_i,
  input  logic               ready_value_i,
  input  logic [15:0]        default_iface_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               changed_o,
  output logic               active_valid_o,
  output logic [15:0]        active_iface_o,
  output logic [31:0]        active_name_o,
  output logic signed [15:0] active_prio_o
);

  upst_pkg::cmd_t cmd;
  upst_pkg::sts_t sts;

  upst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  upst_datapath #(
    .Slots (Slots)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .iface_id_i      (iface_id_i),
    .name_key_i      (name_key_i),
    .route_prio_i    (route_prio_i),
    .ready_value_i   (ready_value_i),
    .default_iface_i (default_iface_i),
    .status_o        (status_o),
    .changed_o       (changed_o),
    .active_valid_o  (active_valid_o),
    .active_iface_o  (active_iface_o),
    .active_name_o   (active_name_o),
    .active_prio_o   (active_prio_o)
  );

endmodule
